// ===== design/pfps_pkg.sv =====
// types, constants and word builder for the flash program/erase sequencer
package pfps_pkg;

   localparam int unsigned ADDRESS_WIDTH     = 16;
   localparam int unsigned BUS_ADDRESS_WIDTH = 15;
   localparam int unsigned BYTE_WIDTH        = 8;
   localparam int unsigned PROGRAM_LIMIT_WIDTH = 10;
   localparam int unsigned ERASE_LIMIT_WIDTH   = 16;
   localparam int unsigned CSR_DATA_WIDTH      = 16;
   localparam int unsigned STEP_WIDTH          = 3;

   localparam logic [BUS_ADDRESS_WIDTH-1:0] ADDR_UNLOCK_A = 15'h0555;
   localparam logic [BUS_ADDRESS_WIDTH-1:0] ADDR_UNLOCK_B = 15'h02AA;
   localparam logic [BUS_ADDRESS_WIDTH-1:0] ADDR_ZERO     = 15'h0000;
   localparam logic [BYTE_WIDTH-1:0] CMD_UNLOCK_A = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] CMD_UNLOCK_B = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] CMD_PROGRAM  = 8'hA0;
   localparam logic [BYTE_WIDTH-1:0] CMD_ERASE    = 8'h80;
   localparam logic [BYTE_WIDTH-1:0] CMD_CHIP     = 8'h10;
   localparam logic [BYTE_WIDTH-1:0] ERASED_BYTE  = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] BYTE_ZERO    = 8'h00;

   localparam logic [PROGRAM_LIMIT_WIDTH-1:0] PROGRAM_LIMIT_RESET = 10'd10;
   localparam logic [ERASE_LIMIT_WIDTH-1:0]   ERASE_LIMIT_RESET   = 16'd10000;

   typedef enum logic [1:0] {
      MODE_PROGRAM = 2'd0,
      MODE_ERASE   = 2'd1,
      MODE_DATA    = 2'd2,
      MODE_TICK    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_REPORT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_WAIT_DATA = 2'd1,
      PH_WAIT_TICK = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PROGRAM = 2'd0,
      KIND_ERASE   = 2'd1,
      KIND_READ    = 2'd2,
      KIND_REPORT  = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_PROGRAM_LIMIT = 1'b0,
      CSR_ERASE_LIMIT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                       bus_op;
      logic [BUS_ADDRESS_WIDTH-1:0] bus_address;
      logic [BYTE_WIDTH-1:0]        bus_data;
      logic                         status;
   } word_type;

   // index of the final word of each burst
   function automatic logic [STEP_WIDTH-1:0] final_step(kind_type kind);
      logic [STEP_WIDTH-1:0] step;
      begin
         unique case (kind)
            KIND_PROGRAM: step = 3'd4;
            KIND_ERASE:   step = 3'd6;
            KIND_READ:    step = 3'd0;
            KIND_REPORT:  step = 3'd0;
            default:      step = 3'd0;
         endcase
         return step;
      end
   endfunction

   function automatic word_type build_word(kind_type kind, logic [STEP_WIDTH-1:0] step,
                                           logic [BUS_ADDRESS_WIDTH-1:0] address,
                                           logic [BYTE_WIDTH-1:0] data, logic status);
      word_type w;
      begin
         w.bus_op      = OP_WRITE;
         w.bus_address = ADDR_ZERO;
         w.bus_data    = BYTE_ZERO;
         w.status      = 1'b0;
         unique case (kind)
            KIND_PROGRAM: begin
               unique case (step)
                  3'd0: begin
                     w.bus_address = ADDR_UNLOCK_A;
                     w.bus_data    = CMD_UNLOCK_A;
                  end
                  3'd1: begin
                     w.bus_address = ADDR_UNLOCK_B;
                     w.bus_data    = CMD_UNLOCK_B;
                  end
                  3'd2: begin
                     w.bus_address = ADDR_UNLOCK_A;
                     w.bus_data    = CMD_PROGRAM;
                  end
                  3'd3: begin
                     w.bus_address = address;
                     w.bus_data    = data;
                  end
                  default: begin
                     w.bus_op      = OP_READ;
                     w.bus_address = address;
                  end
               endcase
            end
            KIND_ERASE: begin
               unique case (step)
                  3'd0, 3'd3: begin
                     w.bus_address = ADDR_UNLOCK_A;
                     w.bus_data    = CMD_UNLOCK_A;
                  end
                  3'd1, 3'd4: begin
                     w.bus_address = ADDR_UNLOCK_B;
                     w.bus_data    = CMD_UNLOCK_B;
                  end
                  3'd2: begin
                     w.bus_address = ADDR_UNLOCK_A;
                     w.bus_data    = CMD_ERASE;
                  end
                  3'd5: begin
                     w.bus_address = ADDR_UNLOCK_A;
                     w.bus_data    = CMD_CHIP;
                  end
                  default: begin
                     w.bus_op = OP_READ;
                  end
               endcase
            end
            KIND_READ: begin
               w.bus_op      = OP_READ;
               w.bus_address = address;
            end
            default: begin
               w.bus_op = OP_REPORT;
               w.status = status;
            end
         endcase
         return w;
      end
   endfunction

endpackage

// ===== design/pfps_req_if.sv =====
// request channel: valid/ready plus request word
interface pfps_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          mode;
   logic [pfps_pkg::ADDRESS_WIDTH-1:0]  address;
   logic [pfps_pkg::BYTE_WIDTH-1:0]     data;

   modport source (output valid, output mode, output address, output data, input ready);
   modport sink (input valid, input mode, input address, input data, output ready);
endinterface

// ===== design/pfps_rsp_if.sv =====
// result channel: valid/ready plus bus cycle or status word
interface pfps_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             bus_op;
   logic [pfps_pkg::BUS_ADDRESS_WIDTH-1:0] bus_address;
   logic [pfps_pkg::BYTE_WIDTH-1:0]        bus_data;
   logic                                   status;
   logic                                   last;

   modport source (output valid, output bus_op, output bus_address, output bus_data,
                   output status, output last, input ready);
   modport sink (input valid, input bus_op, input bus_address, input bus_data,
                 input status, input last, output ready);
endinterface

// ===== design/parallel_flash_program_erase_sequencer.sv =====
// top level: flash program/erase command sequencer with poll tracking
// requests pass through the burst register, result words through the output register
// program gives 5 words, erase 7, read data or tick 0 or 1; one per cycle unless stalled
// throughput: a new request word is taken in the cycle the previous one's last word leaves
//   the burst register; the output register sustains one word per cycle unless stalled
// reset: synchronous; sequencer idle, no words pending, poll limits 10 and 10000
module parallel_flash_program_erase_sequencer (
   input  logic                                      clock,
   input  logic                                      reset,
   pfps_req_if.sink                                  req_chan,
   pfps_rsp_if.source                                rsp_chan,
   input  logic                                      csr_write_enable,
   input  logic                                      csr_index,
   input  logic [pfps_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data
);

   // configuration
   logic [pfps_pkg::PROGRAM_LIMIT_WIDTH-1:0] program_limit_ff;
   logic [pfps_pkg::ERASE_LIMIT_WIDTH-1:0]   erase_limit_ff;

   // sequencer state
   pfps_pkg::phase_type                      phase_ff, phase_in;
   logic                                     erasing_ff, erasing_in;
   logic [pfps_pkg::BUS_ADDRESS_WIDTH-1:0]   target_ff, target_in;
   logic [pfps_pkg::BYTE_WIDTH-1:0]          expected_ff, expected_in;
   logic [pfps_pkg::ERASE_LIMIT_WIDTH-1:0]   poll_count_ff, poll_count_in;

   // burst register: what the accepted word still has to emit
   logic                                     burst_valid_ff, burst_valid_in;
   pfps_pkg::kind_type                       burst_kind_ff, burst_kind_in;
   logic [pfps_pkg::STEP_WIDTH-1:0]          burst_step_ff, burst_step_in;
   logic [pfps_pkg::BUS_ADDRESS_WIDTH-1:0]   burst_address_ff, burst_address_in;
   logic [pfps_pkg::BYTE_WIDTH-1:0]          burst_data_ff, burst_data_in;
   logic                                     burst_status_ff, burst_status_in;

   // output register
   logic                                     out_valid_ff, out_valid_in;
   pfps_pkg::word_type                       out_word_ff, out_word_in;
   logic                                     out_last_ff, out_last_in;

   logic                                     accept;
   logic                                     out_free;
   logic                                     emit;
   logic                                     burst_done;
   logic                                     start_burst;
   logic [pfps_pkg::ERASE_LIMIT_WIDTH-1:0]   limit;
   logic                                     limit_reached;
   logic                                     data_match;
   pfps_pkg::mode_type                       mode;

   assign mode          = pfps_pkg::mode_type'(req_chan.mode);
   assign out_free      = !out_valid_ff || rsp_chan.ready;
   assign emit          = burst_valid_ff && out_free;
   assign burst_done    = emit && (burst_step_ff == pfps_pkg::final_step(burst_kind_ff));
   assign req_chan.ready = !burst_valid_ff || burst_done;
   assign accept        = req_chan.valid && req_chan.ready;

   assign limit = erasing_ff ? erase_limit_ff
                             : {{(pfps_pkg::ERASE_LIMIT_WIDTH - pfps_pkg::PROGRAM_LIMIT_WIDTH){1'b0}},
                                program_limit_ff};
   assign limit_reached = poll_count_ff >= limit;
   assign data_match    = req_chan.data == expected_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (mode)
            pfps_pkg::MODE_PROGRAM, pfps_pkg::MODE_ERASE: begin
               if (phase_ff == pfps_pkg::PH_IDLE) phase_in = pfps_pkg::PH_WAIT_DATA;
            end
            pfps_pkg::MODE_DATA: begin
               if (phase_ff == pfps_pkg::PH_WAIT_DATA) begin
                  phase_in = (limit_reached || data_match) ? pfps_pkg::PH_IDLE
                                                           : pfps_pkg::PH_WAIT_TICK;
               end
            end
            pfps_pkg::MODE_TICK: begin
               if (phase_ff == pfps_pkg::PH_WAIT_TICK) phase_in = pfps_pkg::PH_WAIT_DATA;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // per-phase actions: operation context and burst to emit
   always_comb begin
      erasing_in       = erasing_ff;
      target_in        = target_ff;
      expected_in      = expected_ff;
      poll_count_in    = poll_count_ff;
      start_burst      = 1'b0;
      burst_kind_in    = burst_kind_ff;
      burst_address_in = burst_address_ff;
      burst_data_in    = burst_data_ff;
      burst_status_in  = burst_status_ff;
      if (accept) begin
         unique case (mode)
            pfps_pkg::MODE_PROGRAM: begin
               if (phase_ff == pfps_pkg::PH_IDLE) begin
                  // upper half of the range folds onto the lower
                  target_in        = req_chan.address[pfps_pkg::BUS_ADDRESS_WIDTH-1:0];
                  expected_in      = req_chan.data;
                  erasing_in       = 1'b0;
                  poll_count_in    = '0;
                  start_burst      = 1'b1;
                  burst_kind_in    = pfps_pkg::KIND_PROGRAM;
                  burst_address_in = req_chan.address[pfps_pkg::BUS_ADDRESS_WIDTH-1:0];
                  burst_data_in    = req_chan.data;
               end
            end
            pfps_pkg::MODE_ERASE: begin
               if (phase_ff == pfps_pkg::PH_IDLE) begin
                  target_in        = pfps_pkg::ADDR_ZERO;
                  expected_in      = pfps_pkg::ERASED_BYTE;
                  erasing_in       = 1'b1;
                  poll_count_in    = '0;
                  start_burst      = 1'b1;
                  burst_kind_in    = pfps_pkg::KIND_ERASE;
                  burst_address_in = pfps_pkg::ADDR_ZERO;
               end
            end
            pfps_pkg::MODE_DATA: begin
               if (phase_ff == pfps_pkg::PH_WAIT_DATA && (limit_reached || data_match)) begin
                  // timeout wins even when the byte matches
                  start_burst     = 1'b1;
                  burst_kind_in   = pfps_pkg::KIND_REPORT;
                  burst_status_in = limit_reached;
               end
            end
            pfps_pkg::MODE_TICK: begin
               if (phase_ff == pfps_pkg::PH_WAIT_TICK) begin
                  poll_count_in    = poll_count_ff + 1'b1;
                  start_burst      = 1'b1;
                  burst_kind_in    = pfps_pkg::KIND_READ;
                  burst_address_in = target_ff;
               end
            end
            default: start_burst = 1'b0;
         endcase
      end
   end

   // burst progress
   always_comb begin
      burst_valid_in = burst_valid_ff;
      burst_step_in  = burst_step_ff;
      if (start_burst) begin
         burst_valid_in = 1'b1;
         burst_step_in  = '0;
      end else if (burst_done) begin
         burst_valid_in = 1'b0;
      end else if (emit) begin
         burst_step_in = burst_step_ff + 1'b1;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_word_in  = pfps_pkg::build_word(burst_kind_ff, burst_step_ff, burst_address_ff,
                                             burst_data_ff, burst_status_ff);
         out_last_in  = burst_done;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_limit_ff <= pfps_pkg::PROGRAM_LIMIT_RESET;
         erase_limit_ff   <= pfps_pkg::ERASE_LIMIT_RESET;
         phase_ff         <= pfps_pkg::PH_IDLE;
         erasing_ff       <= 1'b0;
         target_ff        <= '0;
         expected_ff      <= '0;
         poll_count_ff    <= '0;
         burst_valid_ff   <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (pfps_pkg::csr_index_type'(csr_index))
               pfps_pkg::CSR_PROGRAM_LIMIT:
                  program_limit_ff <= csr_write_data[pfps_pkg::PROGRAM_LIMIT_WIDTH-1:0];
               pfps_pkg::CSR_ERASE_LIMIT:
                  erase_limit_ff <= csr_write_data[pfps_pkg::ERASE_LIMIT_WIDTH-1:0];
               default: erase_limit_ff <= erase_limit_ff;
            endcase
         end
         phase_ff       <= phase_in;
         erasing_ff     <= erasing_in;
         target_ff      <= target_in;
         expected_ff    <= expected_in;
         poll_count_ff  <= poll_count_in;
         burst_valid_ff <= burst_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_kind_ff    <= burst_kind_in;
      burst_step_ff    <= burst_step_in;
      burst_address_ff <= burst_address_in;
      burst_data_ff    <= burst_data_in;
      burst_status_ff  <= burst_status_in;
      out_word_ff      <= out_word_in;
      out_last_ff      <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.bus_op      = out_word_ff.bus_op;
   assign rsp_chan.bus_address = out_word_ff.bus_address;
   assign rsp_chan.bus_data    = out_word_ff.bus_data;
   assign rsp_chan.status      = out_word_ff.status;
   assign rsp_chan.last        = out_last_ff;

endmodule

// ===== design/pfps_checker.sv =====
// port-level checks on the result channel, bound to the top level
module pfps_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [1:0]                             rsp_bus_op,
   input logic [pfps_pkg::BUS_ADDRESS_WIDTH-1:0] rsp_bus_address,
   input logic [pfps_pkg::BYTE_WIDTH-1:0]        rsp_bus_data,
   input logic                                   rsp_last
);

   // a stalled word keeps valid, its address and its last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_address) && $stable(rsp_last))
      else $error("stalled result word changed");

   // a status report always closes its word group and carries address zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_op == pfps_pkg::OP_REPORT |-> rsp_last &&
      rsp_bus_address == pfps_pkg::ADDR_ZERO)
      else $error("status report not final or has an address");

   // only write cycles drive data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_op != pfps_pkg::OP_WRITE |-> rsp_bus_data == pfps_pkg::BYTE_ZERO)
      else $error("data driven on a non-write word");

   // every word group ends on a read or a report, never a write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_bus_op != pfps_pkg::OP_WRITE)
      else $error("word group ends on a write cycle");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind parallel_flash_program_erase_sequencer pfps_checker u_pfps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bus_op      (rsp_chan.bus_op),
   .rsp_bus_address (rsp_chan.bus_address),
   .rsp_bus_data    (rsp_chan.bus_data),
   .rsp_last        (rsp_chan.last)
);
